// ===== src/ldf_pkg.sv =====
package ldf_pkg;

	localparam int HEADER_BYTES = 8;
	localparam int FILL_W       = $clog2(HEADER_BYTES);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PING_TYPE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PONG_TYPE   = 2'd2;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd512;
	localparam logic [7:0]  PING_TYPE_RST   = 8'd7;
	localparam logic [7:0]  PONG_TYPE_RST   = 8'd8;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_PONG = 1'b1;

	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(HEADER_BYTES - 1);

	typedef logic [7:0] byte_t;
	typedef byte_t window_t [HEADER_BYTES];

endpackage

// ===== src/length_prefixed_deframer.sv =====
// the result of an accepted byte is registered and shows in the output register in the next cycle
// throughput: one byte per cycle while in_stall is low; parser state and result come from one pass of logic
// an output request waiting under stall blocks intake only while it is not taken
// reset: arst_n asynchronous, active low; parser cleared, registers to 512 / 7 / 8
// restart on an accepted byte clears the parser and the byte gives no result
module length_prefixed_deframer import ldf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            rx_byte,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  kind,
	output logic [7:0]            frame_type,
	output logic [7:0]            frame_flags,
	output logic [15:0]           frame_seq,
	output logic [7:0]            payload_byte,
	output logic                  last_of_frame
);

	logic [15:0]       max_payload_q;
	logic [7:0]        ping_type_q;
	logic [7:0]        pong_type_q;

	window_t           win_q, win_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              in_payload_q, in_payload_d;
	logic [15:0]       left_q, left_d;
	logic [7:0]        type_q, type_d;
	logic [7:0]        flags_q, flags_d;
	logic [15:0]       seq_q, seq_d;

	logic              out_valid_q;
	logic              kind_q;
	logic [7:0]        type_out_q;
	logic [7:0]        flags_out_q;
	logic [15:0]       seq_out_q;
	logic [7:0]        data_out_q;
	logic              last_out_q;

	logic              accept;
	logic              res_v;
	logic              res_kind;
	logic [7:0]        res_data;
	logic              res_last;
	logic [15:0]       left_m1;
	logic [31:0]       len;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign left_m1  = left_q - 16'd1;
	assign len      = {rx_byte, win_q[6], win_q[5], win_q[4]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			ping_type_q   <= PING_TYPE_RST;
			pong_type_q   <= PONG_TYPE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				REG_PING_TYPE:   ping_type_q   <= cfg_data[7:0];
				REG_PONG_TYPE:   pong_type_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		win_d        = win_q;
		fill_d       = fill_q;
		in_payload_d = in_payload_q;
		left_d       = left_q;
		type_d       = type_q;
		flags_d      = flags_q;
		seq_d        = seq_q;
		res_v        = 1'b0;
		res_kind     = KIND_DATA;
		res_data     = 8'd0;
		res_last     = 1'b0;
		if (accept) begin
			if (restart) begin
				for (int i = 0; i < HEADER_BYTES; i++) begin
					win_d[i] = 8'd0;
				end
				fill_d       = '0;
				in_payload_d = 1'b0;
				left_d       = 16'd0;
				type_d       = 8'd0;
				flags_d      = 8'd0;
				seq_d        = 16'd0;
			end else if (in_payload_q) begin
				left_d = left_m1;
				if (left_m1 == 16'd0) begin
					in_payload_d = 1'b0;
				end
				if (type_q == ping_type_q) begin
					if (left_m1 == 16'd0) begin
						res_v    = 1'b1;
						res_kind = KIND_PONG;
						res_last = 1'b1;
					end
				end else if (type_q != pong_type_q) begin
					res_v    = 1'b1;
					res_data = rx_byte;
					res_last = (left_m1 == 16'd0);
				end
			end else begin
				win_d[fill_q] = rx_byte;
				if (fill_q == FILL_LAST) begin
					if (len[31:16] != 16'd0 || len[15:0] > max_payload_q) begin
						// resync: drop the oldest byte
						for (int i = 0; i < HEADER_BYTES - 2; i++) begin
							win_d[i] = win_q[i+1];
						end
						win_d[HEADER_BYTES-2] = rx_byte;
						win_d[HEADER_BYTES-1] = 8'd0;
						fill_d = FILL_LAST;
					end else begin
						type_d       = win_q[0];
						flags_d      = win_q[1];
						seq_d        = {win_q[3], win_q[2]};
						left_d       = len[15:0];
						fill_d       = '0;
						in_payload_d = (len[15:0] != 16'd0);
						if (len[15:0] == 16'd0 && win_q[0] == ping_type_q) begin
							res_v    = 1'b1;
							res_kind = KIND_PONG;
							res_last = 1'b1;
						end
					end
				end else begin
					fill_d = fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HEADER_BYTES; i++) begin
				win_q[i] <= 8'd0;
			end
			fill_q       <= '0;
			in_payload_q <= 1'b0;
			left_q       <= 16'd0;
			type_q       <= 8'd0;
			flags_q      <= 8'd0;
			seq_q        <= 16'd0;
			out_valid_q  <= 1'b0;
		end else begin
			win_q        <= win_d;
			fill_q       <= fill_d;
			in_payload_q <= in_payload_d;
			left_q       <= left_d;
			type_q       <= type_d;
			flags_q      <= flags_d;
			seq_q        <= seq_d;
			if (!in_stall) begin
				out_valid_q <= accept && res_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_v) begin
			kind_q      <= res_kind;
			type_out_q  <= type_d;
			flags_out_q <= flags_d;
			seq_out_q   <= seq_d;
			data_out_q  <= res_data;
			last_out_q  <= res_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign frame_type    = type_out_q;
	assign frame_flags   = flags_out_q;
	assign frame_seq     = seq_out_q;
	assign payload_byte  = data_out_q;
	assign last_of_frame = last_out_q;

`ifndef NO_ASSERTIONS
	a_payload_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (fill_q == '0 && left_q != 16'd0))
		else $error("payload phase with header bytes pending or no bytes left");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && restart) |=> (!in_payload_q && fill_q == '0 && !$rose(out_valid_q)))
		else $error("restart left parser state or produced a result");

	a_pong_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_PONG) |-> (last_out_q && data_out_q == 8'd0))
		else $error("pong request without last mark or with data");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_stall && !accept) |=> !out_valid_q)
		else $error("result appeared without an accepted byte");
`endif

endmodule

// ===== test/tb_length_prefixed_deframer.sv =====
`timescale 1ns / 100ps

module tb_length_prefixed_deframer import ldf_pkg::*; ();

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int LONG_HOLD   = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int DIR_ROWS    = 21;

	typedef struct packed {
		logic        kind;
		byte_t       ftype;
		byte_t       flags;
		logic [15:0] seq;
		byte_t       data;
		logic        last;
	} reply_t;

	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_t;

	typedef struct {
		byte_t  rx;
		logic   rst;
		chk_t   mode;
		reply_t res;
	} dir_row_t;

	localparam reply_t NO_REPLY = '0;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            rx_byte = '0;
	logic                  restart = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  kind;
	logic [7:0]            frame_type;
	logic [7:0]            frame_flags;
	logic [15:0]           frame_seq;
	logic [7:0]            payload_byte;
	logic                  last_of_frame;

	// deframer state as predicted
	logic [15:0] max_len;
	byte_t       ping_code;
	byte_t       pong_code;
	window_t     hdr_win;
	int          hdr_fill;
	bit          pl_active;
	logic [15:0] pl_left;
	byte_t       cur_type;
	byte_t       cur_flags;
	logic [15:0] cur_seq;

	reply_t replies_due [$];
	int     mismatches = 0;
	int     items_sent = 0;
	int     quiet_cycles = 0;
	int     hold_asked = 0;
	int     hold_done = 0;
	bit     tx_steady = 0;
	bit     rx_steady = 0;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{8'hff, 1'b1, CHK_NONE, NO_REPLY},
		'{8'h01, 1'b0, CHK_NONE, NO_REPLY},
		'{8'hff, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h34, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h12, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h02, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h00, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h00, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h00, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h00, 1'b0, CHK_TYPED, '{KIND_DATA, 8'h01, 8'hff, 16'h1234, 8'h00, 1'b0}},
		'{8'hff, 1'b0, CHK_TYPED, '{KIND_DATA, 8'h01, 8'hff, 16'h1234, 8'hff, 1'b1}},
		// zero-length ping
		'{PING_TYPE_RST, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h00, 1'b0, CHK_NONE, NO_REPLY},
		'{8'hff, 1'b0, CHK_NONE, NO_REPLY},
		'{8'hff, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h00, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h00, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h00, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h00, 1'b0, CHK_TYPED, '{KIND_PONG, PING_TYPE_RST, 8'h00, 16'hffff, 8'h00, 1'b1}},
		// header cut by restart
		'{PING_TYPE_RST, 1'b0, CHK_NONE, NO_REPLY},
		'{8'h00, 1'b1, CHK_NONE, NO_REPLY}
	};

	length_prefixed_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.frame_type   (frame_type),
		.frame_flags  (frame_flags),
		.frame_seq    (frame_seq),
		.payload_byte (payload_byte),
		.last_of_frame(last_of_frame)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	task automatic clear_parser();
		foreach (hdr_win[i]) hdr_win[i] = '0;
		hdr_fill  = 0;
		pl_active = 0;
		pl_left   = '0;
		cur_type  = '0;
		cur_flags = '0;
		cur_seq   = '0;
	endtask

	task automatic deframe_step(input byte_t rx, input logic rst, output bit got,
			output reply_t r);
		logic [31:0] len;
		got = 0;
		r = NO_REPLY;
		if (rst) begin
			clear_parser();
			return;
		end
		if (pl_active) begin
			pl_left = pl_left - 16'd1;
			if (pl_left == 0) pl_active = 0;
			if (cur_type == ping_code) begin
				if (pl_left == 0) begin
					got = 1;
					r = '{KIND_PONG, cur_type, cur_flags, cur_seq, 8'h00, 1'b1};
				end
			end else if (cur_type != pong_code) begin
				got = 1;
				r = '{KIND_DATA, cur_type, cur_flags, cur_seq, rx, pl_left == 0};
			end
			return;
		end
		hdr_win[hdr_fill] = rx;
		hdr_fill++;
		if (hdr_fill < HEADER_BYTES) return;
		len = {hdr_win[7], hdr_win[6], hdr_win[5], hdr_win[4]};
		if (len > {16'd0, max_len}) begin
			// slide by one byte and wait for the next
			for (int i = 0; i < HEADER_BYTES - 1; i++) hdr_win[i] = hdr_win[i + 1];
			hdr_win[HEADER_BYTES - 1] = '0;
			hdr_fill = HEADER_BYTES - 1;
			return;
		end
		cur_type  = hdr_win[0];
		cur_flags = hdr_win[1];
		cur_seq   = {hdr_win[3], hdr_win[2]};
		pl_left   = len[15:0];
		hdr_fill  = 0;
		pl_active = (pl_left != 0);
		if (!pl_active && cur_type == ping_code) begin
			got = 1;
			r = '{KIND_PONG, cur_type, cur_flags, cur_seq, 8'h00, 1'b1};
		end
	endtask

	task automatic send_byte(input byte_t rx, input logic rst, input chk_t mode,
			input reply_t typed);
		int     gap;
		bit     got;
		reply_t r;
		gap = 0;
		if (!tx_steady && $urandom_range(0, 2) == 0) gap = idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= rx;
		restart  <= rst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		deframe_step(rx, rst, got, r);
		case (mode)
			CHK_MODEL: begin
				if (got) replies_due.push_back(r);
			end
			CHK_TYPED: begin
				replies_due.push_back(typed);
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_stream_byte(input byte_t rx);
		send_byte(rx, $urandom_range(0, 299) == 0, CHK_MODEL, NO_REPLY);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_MAX_PAYLOAD: max_len = val;
			REG_PING_TYPE:   ping_code = val[7:0];
			REG_PONG_TYPE:   pong_code = val[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic apply_config(input logic [15:0] max_v, input byte_t ping_v, input byte_t pong_v);
		drain();
		write_reg(REG_UNUSED, 16'($urandom));
		write_reg(REG_MAX_PAYLOAD, max_v);
		write_reg(REG_PING_TYPE, {8'($urandom), ping_v});
		write_reg(REG_PONG_TYPE, {8'($urandom), pong_v});
		cfg_we <= 1'b0;
	endtask

	task automatic put_frame(input bit cut);
		byte_t       hdr [HEADER_BYTES];
		byte_t       ftype;
		logic [15:0] seq;
		logic [31:0] len;
		bit          oversize;
		int          r;
		int          n;
		r = $urandom_range(0, 9);
		ftype = (r < 4) ? ping_code : (r < 6) ? pong_code : byte_t'($urandom);
		seq = 16'($urandom);
		oversize = 0;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			len = 0;
		end else if (r < 55) begin
			len = $urandom_range(1, 8);
		end else if (r < 72) begin
			len = $urandom_range(9, 40);
		end else if (r < 85) begin
			len = (max_len <= 48) ? max_len : $urandom_range(41, 48);
		end else begin
			oversize = 1;
			if (max_len != 16'hffff && $urandom_range(0, 1) == 1) begin
				len = max_len + 1 + $urandom_range(0, 3);
			end else begin
				len = $urandom | 32'h0001_0000;
			end
		end
		if (!oversize && len > max_len) len = max_len;
		// stray bytes ahead of the frame
		if ($urandom_range(0, 24) == 0) begin
			repeat ($urandom_range(1, 6)) send_stream_byte(byte_t'($urandom));
		end
		hdr = '{ftype, byte_t'($urandom), seq[7:0], seq[15:8],
			len[7:0], len[15:8], len[23:16], len[31:24]};
		foreach (hdr[i]) send_stream_byte(hdr[i]);
		if (oversize) begin
			if ($urandom_range(0, 9) < 6) begin
				send_byte(byte_t'($urandom), 1'b1, CHK_MODEL, NO_REPLY);
			end
			return;
		end
		n = len;
		if (cut && len > 1) n = $urandom_range(1, len - 1);
		repeat (n) send_stream_byte(byte_t'($urandom));
	endtask

	task automatic run_phase(input int n_items);
		int start;
		start = items_sent;
		// payload left over from the previous settings
		while (pl_active && pl_left <= 64) begin
			send_byte(byte_t'($urandom), 1'b0, CHK_MODEL, NO_REPLY);
		end
		while (items_sent - start < n_items) begin
			if ((pl_active && pl_left > 64) || (hdr_fill != 0 && $urandom_range(0, 9) < 7)) begin
				send_byte(byte_t'($urandom), 1'b1, CHK_MODEL, NO_REPLY);
			end
			put_frame(1'b0);
		end
		if ($urandom_range(0, 1) == 1) put_frame(1'b1);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				$error("unexpected result: kind %0h seq 0x%0h data 0x%0h",
					kind, frame_seq, payload_byte);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				check_field("kind", 16'(want.kind), 16'(kind));
				check_field("frame_type", 16'(want.ftype), 16'(frame_type));
				check_field("frame_flags", 16'(want.flags), 16'(frame_flags));
				check_field("frame_seq", want.seq, frame_seq);
				check_field("payload_byte", 16'(want.data), 16'(payload_byte));
				check_field("last_of_frame", 16'(want.last), 16'(last_of_frame));
			end
		end
	end

	initial begin : receiver
		int left;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				if (hold_done != hold_asked) begin
					left = LONG_HOLD;
					hold_done++;
				end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
					left = idle_len();
				end
			end
			out_stall <= (left != 0);
			if (left != 0) left--;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_length_prefixed_deframer NOT OK");
				$finish;
			end
		end
	end

	initial begin : stimulus
		byte_t tie;
		max_len   = MAX_PAYLOAD_RST;
		ping_code = PING_TYPE_RST;
		pong_code = PONG_TYPE_RST;
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_byte(dir_tab[i].rx, dir_tab[i].rst, dir_tab[i].mode, dir_tab[i].res);
		end

		// receiver holds off while the sender keeps pushing
		tx_steady = 1;
		apply_config(16'd16, PING_TYPE_RST, PONG_TYPE_RST);
		hold_asked++;
		run_phase(310);
		tx_steady = 0;

		apply_config(16'd0, 8'h00, 8'hff);
		run_phase(310);

		apply_config(16'hffff, 8'hff, 8'h00);
		run_phase(310);

		// ping and pong share one code
		tie = byte_t'($urandom);
		apply_config(16'd40, tie, tie);
		run_phase(310);

		apply_config(16'($urandom_range(1, 64)), byte_t'($urandom), byte_t'($urandom));
		run_phase(150);
		drain();
		run_phase(160);

		tx_steady = 1;
		rx_steady = 1;
		apply_config(MAX_PAYLOAD_RST, PING_TYPE_RST, PONG_TYPE_RST);
		run_phase(300);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_length_prefixed_deframer OK");
		end else begin
			$display("tb_length_prefixed_deframer NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/ldf_pkg.sv
src/length_prefixed_deframer.sv
test/tb_length_prefixed_deframer.sv
